FILE: src/ids_pkg.sv
// shared types, codes and defaults for the ignition and diffusion step unit
// no dependencies
`default_nettype none

package ids_pkg;

  // default grid capacity
  localparam int MAX_CELLS_DEF = 1024;

  // operand and product widths of the shared multiplier
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // action codes
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // cell phases
  localparam logic [1:0] PH_UNBURNT = 2'd0;
  localparam logic [1:0] PH_BURNING = 2'd1;
  localparam logic [1:0] PH_BURNT   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_TIME_STEP     = 3'd0;
  localparam logic [2:0] REG_BURN_DURATION = 3'd1;
  localparam logic [2:0] REG_IGNITION_TEMP = 3'd2;
  localparam logic [2:0] REG_DIFFUSION     = 3'd3;
  localparam logic [2:0] REG_HEAT_GAIN     = 3'd4;
  localparam logic [2:0] REG_CELL_COUNT    = 3'd5;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PRE1,
    ST_PRE2,
    ST_RD,
    ST_MUL1,
    ST_MUL2,
    ST_WB,
    ST_FIN
  } ids_state_t;

endpackage

`default_nettype wire

FILE: src/ids_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module ids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/ids_mul.sv
// shared signed multiplier with registered product
// depends on ids_pkg
`default_nettype none

module ids_mul (
  input  wire logic                               clk,
  input  wire logic signed [ids_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [ids_pkg::MUL_B_W-1:0] b,
  output logic      signed [ids_pkg::MUL_P_W-1:0] prod
);

  // one product per cycle
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

FILE: src/ignition_diffusion_step_unit.sv
// top level: sequencer, cell stores and per-cell update for the ignition grid
// depends on ids_pkg, ids_ram, ids_mul
`default_nettype none

// One-dimensional ignition and diffusion grid. Raise start while busy is low to
// issue a transaction; exactly one result comes back on done, held on the
// result ports for that single cycle, and the receiver cannot stall it. Load and
// unused actions raise done in the cycle after they are taken; a read passes
// through the read state first. A step sweeps the active cells once, each cell
// going through read, diffusion multiply, heat multiply and write back, with both
// multiplies done by the one shared multiplier and busy high until the result.
// After reset the phase store is cleared one entry a cycle with busy high;
// configuration writes are taken throughout.
module ignition_diffusion_step_unit #(
  parameter int MAX_CELLS = ids_pkg::MAX_CELLS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done,
  input  wire logic               wr_en,
  input  wire logic [2:0]         wr_index,
  input  wire logic [31:0]        wr_data,
  input  wire logic [1:0]         action,
  input  wire logic [10:0]        cell_index,
  input  wire logic signed [31:0] load_temp,
  input  wire logic [15:0]        load_conc,
  output logic [10:0]             front_position,
  output logic signed [31:0]      peak_temp,
  output logic signed [31:0]      cell_temp,
  output logic [1:0]              cell_phase
);

  localparam int AW = $clog2(MAX_CELLS);

  // configuration registers
  logic [31:0]        time_step;
  logic [31:0]        burn_duration;
  logic signed [31:0] ignition_temp;
  logic [15:0]        diffusion_gain;
  logic [31:0]        heat_gain;
  logic [10:0]        cell_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= 32'd65536;
      burn_duration  <= 32'd65536;
      ignition_temp  <= 32'sd65536;
      diffusion_gain <= 16'd6554;
      heat_gain      <= 32'd65536;
      cell_count     <= 11'd1024;
    end else if (wr_en) begin
      unique case (wr_index)
        ids_pkg::REG_TIME_STEP:     time_step      <= wr_data;
        ids_pkg::REG_BURN_DURATION: burn_duration  <= wr_data;
        ids_pkg::REG_IGNITION_TEMP: ignition_temp  <= wr_data;
        ids_pkg::REG_DIFFUSION:     diffusion_gain <= wr_data[15:0];
        ids_pkg::REG_HEAT_GAIN:     heat_gain      <= wr_data;
        ids_pkg::REG_CELL_COUNT:    cell_count     <= wr_data[10:0];
        default: ;
      endcase
    end
  end

  ids_pkg::ids_state_t state, state_next;

  // sequencer and datapath registers
  logic [AW-1:0]      idx;
  logic [AW-1:0]      last;
  logic signed [31:0] tl, tm, tr;
  logic signed [31:0] np, nc, first_t;
  logic signed [39:0] acc;
  logic [1:0]         ph_r;
  logic               on_r, ign_r;
  logic [31:0]        end_r;
  logic               found;
  logic [10:0]        fcell;
  logic signed [31:0] fpeak;
  logic [31:0]        elapsed;
  logic [10:0]        front_cell;
  logic signed [31:0] front_peak;
  logic               rd_ok;

  // ram ports
  logic               t_we, c_we, p_we, b_we;
  logic [AW-1:0]      t_waddr, t_raddr, p_raddr;
  logic signed [31:0] t_wdata;
  logic [31:0]        t_rdata, b_rdata;
  logic [15:0]        c_rdata;
  logic [1:0]         p_rdata, p_wdata;

  // multiplier operands
  logic signed [ids_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ids_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ids_pkg::MUL_P_W-1:0] prod;

  // combinational helpers
  logic               in_ok;
  logic [AW-1:0]      in_addr;
  logic [31:0]        n_clamp;
  logic signed [31:0] tr_sel;
  logic signed [34:0] lap;
  logic [1:0]         ph_new;
  logic               on_new, ign_new;
  logic [32:0]        end_sum;
  logic [32:0]        time_sum;
  logic signed [ids_pkg::MUL_P_W-1:0] diff_r, heat_r;
  logic signed [39:0] sum;
  logic signed [31:0] new_t;
  logic signed [31:0] edge_peak;

  assign in_ok   = (cell_index != 11'd0) && (32'(cell_index) <= 32'(MAX_CELLS));
  assign in_addr = AW'(cell_index - 11'd1);
  assign n_clamp = (cell_count < 11'd3) ? 32'd3 :
                   ((32'(cell_count) > 32'(MAX_CELLS)) ? 32'(MAX_CELLS) : 32'(cell_count));

  ids_ram #(.WIDTH(32), .DEPTH(MAX_CELLS)) u_temp (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  ids_ram #(.WIDTH(16), .DEPTH(MAX_CELLS)) u_conc (
    .clk(clk), .we(c_we), .waddr(in_addr), .wdata(load_conc),
    .raddr(idx), .rdata(c_rdata)
  );

  ids_ram #(.WIDTH(2), .DEPTH(MAX_CELLS)) u_phase (
    .clk(clk), .we(p_we), .waddr(idx), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  ids_ram #(.WIDTH(32), .DEPTH(MAX_CELLS)) u_burn_end (
    .clk(clk), .we(b_we), .waddr(idx), .wdata(end_r),
    .raddr(idx), .rdata(b_rdata)
  );

  ids_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  // per-cell arithmetic: phase update, laplacian, rounding and saturation
  always_comb begin
    tr_sel   = (idx == last) ? tl : $signed(t_rdata);
    lap      = 35'(tl) + 35'(tr_sel) - (35'(tm) <<< 1);
    end_sum  = {1'b0, elapsed} + {1'b0, burn_duration};
    time_sum = {1'b0, elapsed} + {1'b0, time_step};
    ph_new   = p_rdata;
    on_new   = 1'b0;
    ign_new  = 1'b0;
    unique case (p_rdata)
      ids_pkg::PH_UNBURNT: begin
        if (tm >= ignition_temp) begin
          ph_new  = ids_pkg::PH_BURNING;
          on_new  = 1'b1;
          ign_new = 1'b1;
        end
      end
      ids_pkg::PH_BURNING: begin
        if (b_rdata > elapsed) begin
          on_new = 1'b1;
        end else begin
          ph_new = ids_pkg::PH_BURNT;
        end
      end
      default: ;
    endcase
    diff_r = (prod + ids_pkg::MUL_P_W'(32768)) >>> 16;
    heat_r = (prod + ids_pkg::MUL_P_W'(16384)) >>> 15;
    sum    = acc + (on_r ? 40'(heat_r) : 40'sd0);
    if (sum > 40'sd2147483647) begin
      new_t = 32'sh7fffffff;
    end else if (sum < -40'sd2147483648) begin
      new_t = 32'sh80000000;
    end else begin
      new_t = sum[31:0];
    end
    edge_peak = 32'sd0;
    if (nc >= edge_peak) begin
      edge_peak = nc;
    end
    if (first_t > edge_peak) begin
      edge_peak = first_t;
    end
    if (state == ids_pkg::ST_MUL1) begin
      mul_a = lap;
      mul_b = $signed({1'b0, diffusion_gain});
    end else begin
      mul_a = $signed({3'b000, heat_gain});
      mul_b = $signed({1'b0, c_rdata});
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ids_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram control
  always_comb begin
    state_next = state;
    busy       = (state != ids_pkg::ST_IDLE);
    t_we       = 1'b0;
    c_we       = 1'b0;
    p_we       = 1'b0;
    b_we       = 1'b0;
    t_waddr    = idx;
    t_wdata    = new_t;
    t_raddr    = idx;
    p_raddr    = idx;
    p_wdata    = ph_r;
    unique case (state)
      ids_pkg::ST_CLEAR: begin
        p_we    = 1'b1;
        p_wdata = ids_pkg::PH_UNBURNT;
        if (32'(idx) == 32'(MAX_CELLS - 1)) begin
          state_next = ids_pkg::ST_IDLE;
        end
      end
      ids_pkg::ST_IDLE: begin
        t_raddr = (action == ids_pkg::ACT_READ) ? in_addr : '0;
        p_raddr = in_addr;
        t_waddr = in_addr;
        t_wdata = load_temp;
        if (start) begin
          priority if (action == ids_pkg::ACT_LOAD) begin
            t_we = in_ok;
            c_we = in_ok;
          end else if (action == ids_pkg::ACT_STEP) begin
            state_next = ids_pkg::ST_PRE1;
          end else if (action == ids_pkg::ACT_READ) begin
            state_next = ids_pkg::ST_READ;
          end
        end
      end
      ids_pkg::ST_READ: state_next = ids_pkg::ST_IDLE;
      ids_pkg::ST_PRE1: begin
        t_raddr    = AW'(1);
        state_next = ids_pkg::ST_PRE2;
      end
      ids_pkg::ST_PRE2: state_next = ids_pkg::ST_RD;
      ids_pkg::ST_RD: begin
        t_raddr    = idx + AW'(1);
        state_next = ids_pkg::ST_MUL1;
      end
      ids_pkg::ST_MUL1: state_next = ids_pkg::ST_MUL2;
      ids_pkg::ST_MUL2: state_next = ids_pkg::ST_WB;
      ids_pkg::ST_WB: begin
        t_we = 1'b1;
        p_we = 1'b1;
        b_we = ign_r;
        state_next = (idx == last) ? ids_pkg::ST_FIN : ids_pkg::ST_RD;
      end
      ids_pkg::ST_FIN: state_next = ids_pkg::ST_IDLE;
      default: state_next = ids_pkg::ST_IDLE;
    endcase
  end

  // control counters and front state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      done       <= 1'b0;
      elapsed    <= '0;
      front_cell <= '0;
      front_peak <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ids_pkg::ST_CLEAR: idx <= idx + AW'(1);
        ids_pkg::ST_IDLE: begin
          idx <= '0;
          if (start && action != ids_pkg::ACT_STEP && action != ids_pkg::ACT_READ) begin
            done <= 1'b1;
          end
        end
        ids_pkg::ST_READ: done <= 1'b1;
        ids_pkg::ST_WB: idx <= idx + AW'(1);
        ids_pkg::ST_FIN: begin
          done <= 1'b1;
          if (found) begin
            front_cell <= fcell;
            front_peak <= fpeak;
          end else begin
            front_peak <= edge_peak;
          end
          elapsed <= time_sum[32] ? 32'hffffffff : time_sum[31:0];
        end
        default: ;
      endcase
    end
  end

  // payload registers of the sweep and the result
  always_ff @(posedge clk) begin
    unique case (state)
      ids_pkg::ST_IDLE: begin
        rd_ok      <= in_ok;
        found      <= 1'b0;
        last       <= AW'(n_clamp - 32'd1);
        cell_temp  <= '0;
        cell_phase <= ids_pkg::PH_UNBURNT;
      end
      ids_pkg::ST_READ: begin
        cell_temp  <= rd_ok ? $signed(t_rdata) : 32'sd0;
        cell_phase <= rd_ok ? p_rdata : ids_pkg::PH_UNBURNT;
      end
      ids_pkg::ST_PRE1: tm <= t_rdata;
      ids_pkg::ST_PRE2: tl <= t_rdata;
      ids_pkg::ST_MUL1: begin
        tr    <= tr_sel;
        ph_r  <= ph_new;
        on_r  <= on_new;
        ign_r <= ign_new;
        end_r <= end_sum[32] ? 32'hffffffff : end_sum[31:0];
      end
      ids_pkg::ST_MUL2: acc <= 40'(tm) + 40'(diff_r);
      ids_pkg::ST_WB: begin
        tl <= tm;
        tm <= tr;
        np <= nc;
        nc <= new_t;
        if (idx == '0) begin
          first_t <= new_t;
        end
        // new cell idx-1 is a strict local maximum
        if (idx >= AW'(2) && nc > np && nc > new_t) begin
          found <= 1'b1;
          fcell <= 11'(idx);
          fpeak <= nc;
        end
      end
      default: ;
    endcase
  end

  assign front_position = front_cell;
  assign peak_temp      = front_peak;

endmodule

`default_nettype wire

FILE: test/ignition_diffusion_step_checker.sv
// checker for the ignition and diffusion step unit: watches the ports, predicts
// each result from its own model of the grid and compares; depends on ids_pkg
`timescale 1ns / 100ps

module ignition_diffusion_step_checker
  import ids_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               done,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic [1:0]         action,
  input  logic [10:0]        cell_index,
  input  logic signed [31:0] load_temp,
  input  logic [15:0]        load_conc,
  input  logic [10:0]        front_position,
  input  logic signed [31:0] peak_temp,
  input  logic signed [31:0] cell_temp,
  input  logic [1:0]         cell_phase,
  input  logic               end_check,
  output int                 fail_count
);

  localparam int GRID = MAX_CELLS_DEF;

  typedef struct packed {
    logic [10:0]        pos;
    logic signed [31:0] peak;
    logic signed [31:0] temp;
    logic [1:0]         phase;
  } grid_report_t;

  grid_report_t report_q[$];

  // model of the grid
  logic signed [31:0] temp_mem [GRID];
  logic [15:0]        conc_mem [GRID];
  logic [1:0]         phase_mem [GRID];
  logic [31:0]        burn_end_mem [GRID];
  logic [31:0]        sim_clock;
  logic [10:0]        front_idx;
  logic signed [31:0] front_val;

  // model of the registers
  logic [31:0]        cfg_dt, cfg_burn, cfg_heat;
  logic signed [31:0] cfg_ignite;
  logic [15:0]        cfg_diff;
  logic [10:0]        cfg_cells;

  int errs = 0;
  int shown = 0;
  bit end_seen = 0;

  assign fail_count = errs;

  function automatic logic [31:0] add_sat_u32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_s32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // one time step over the active cells
  function automatic void grid_advance();
    int n;
    logic [31:0] now;
    logic signed [31:0] next_t [GRID];
    bit lit [GRID];
    longint lft, rgt, mid, lap, acc;
    longint unsigned heat;
    bit found;
    n = (cfg_cells < 3) ? 3 : int'(cfg_cells);
    if (n > GRID) n = GRID;
    now = sim_clock;
    found = 0;

    // phase update from the old temperatures
    for (int i = 0; i < n; i++) begin
      lit[i] = 0;
      if (phase_mem[i] == PH_UNBURNT) begin
        if (temp_mem[i] >= cfg_ignite) begin
          phase_mem[i] = PH_BURNING;
          burn_end_mem[i] = add_sat_u32(now, cfg_burn);
          lit[i] = 1;
        end
      end else if (phase_mem[i] == PH_BURNING) begin
        if (burn_end_mem[i] > now) lit[i] = 1;
        else phase_mem[i] = PH_BURNT;
      end
    end

    // diffusion with mirrored edges plus heat release
    for (int i = 0; i < n; i++) begin
      lft = temp_mem[(i == 0) ? 1 : i - 1];
      rgt = temp_mem[(i == n - 1) ? n - 2 : i + 1];
      mid = temp_mem[i];
      lap = lft + rgt - 2 * mid;
      acc = mid + ((lap * longint'(cfg_diff) + 64'sd32768) >>> 16);
      if (lit[i]) begin
        heat = longint'(cfg_heat) * longint'(conc_mem[i]);
        acc += longint'((heat + 64'd16384) >> 15);
      end
      next_t[i] = clamp_s32(acc);
    end
    for (int i = 0; i < n; i++) temp_mem[i] = next_t[i];

    // front scan from the top down
    for (int i = n - 2; i >= 1 && !found; i--) begin
      if (temp_mem[i] > temp_mem[i - 1] && temp_mem[i] > temp_mem[i + 1]) begin
        front_idx = 11'(i + 1);
        front_val = temp_mem[i];
        found = 1;
      end
    end
    if (!found) begin
      front_val = 0;
      if (temp_mem[n - 1] >= front_val) front_val = temp_mem[n - 1];
      if (temp_mem[0] > front_val) front_val = temp_mem[0];
    end
    sim_clock = add_sat_u32(sim_clock, cfg_dt);
  endfunction

  always @(posedge clk) begin
    grid_report_t exp_r, got_r;
    bit ok;
    if (rst) begin
      cfg_dt = 32'd65536;
      cfg_burn = 32'd65536;
      cfg_ignite = 32'sd65536;
      cfg_diff = 16'd6554;
      cfg_heat = 32'd65536;
      cfg_cells = 11'd1024;
      for (int i = 0; i < GRID; i++) begin
        temp_mem[i] = 0;
        conc_mem[i] = 0;
        phase_mem[i] = PH_UNBURNT;
        burn_end_mem[i] = 0;
      end
      sim_clock = 0;
      front_idx = 0;
      front_val = 0;
      report_q.delete();
    end else begin
      // register writes
      if (wr_en) begin
        case (wr_index)
          REG_TIME_STEP:     cfg_dt = wr_data;
          REG_BURN_DURATION: cfg_burn = wr_data;
          REG_IGNITION_TEMP: cfg_ignite = wr_data;
          REG_DIFFUSION:     cfg_diff = wr_data[15:0];
          REG_HEAT_GAIN:     cfg_heat = wr_data;
          REG_CELL_COUNT:    cfg_cells = wr_data[10:0];
          default: ;
        endcase
      end

      // accepted transaction
      if (start && !busy) begin
        exp_r.temp = 0;
        exp_r.phase = PH_UNBURNT;
        case (action)
          ACT_LOAD: begin
            if (cell_index >= 1 && cell_index <= GRID) begin
              temp_mem[cell_index - 1] = load_temp;
              conc_mem[cell_index - 1] = load_conc;
            end
          end
          ACT_STEP: grid_advance();
          ACT_READ: begin
            if (cell_index >= 1 && cell_index <= GRID) begin
              exp_r.temp = temp_mem[cell_index - 1];
              exp_r.phase = phase_mem[cell_index - 1];
            end
          end
          default: ;
        endcase
        exp_r.pos = front_idx;
        exp_r.peak = front_val;
        report_q.push_back(exp_r);
      end

      // result strobe
      if (done) begin
        got_r = '{front_position, peak_temp, cell_temp, cell_phase};
        if (report_q.size() == 0) begin
          errs++;
          if (shown < 10) begin
            shown++;
            $display("unexpected result pos %0d peak %0d temp %0d phase %0d",
                     got_r.pos, got_r.peak, got_r.temp, got_r.phase);
          end
        end else begin
          exp_r = report_q.pop_front();
          ok = (got_r.pos === exp_r.pos) && (got_r.peak === exp_r.peak) &&
               (got_r.temp === exp_r.temp) && (got_r.phase === exp_r.phase);
          if (!ok) begin
            errs++;
            if (shown < 10) begin
              shown++;
              $display("mismatch exp pos %0d peak %0d temp %0d phase %0d", exp_r.pos,
                       exp_r.peak, exp_r.temp, exp_r.phase);
              $display("         got pos %0d peak %0d temp %0d phase %0d", got_r.pos,
                       got_r.peak, got_r.temp, got_r.phase);
            end
          end
        end
      end

      // leftover expectations at the end
      if (end_check && !end_seen) begin
        end_seen = 1;
        if (report_q.size() != 0) begin
          errs += report_q.size();
          $display("%0d results never arrived", report_q.size());
        end
      end
    end
  end

endmodule

FILE: test/ignition_diffusion_step_unit_tb.sv
// testbench top for the ignition and diffusion step unit: clock, reset, stimulus
// and verdict; depends on ids_pkg, the unit and ignition_diffusion_step_checker
`timescale 1ns / 100ps

module ignition_diffusion_step_unit_tb;
  import ids_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               wr_en = 1'b0;
  logic [2:0]         wr_index = REG_TIME_STEP;
  logic [31:0]        wr_data = '0;
  logic [1:0]         action = ACT_READ;
  logic [10:0]        cell_index = '0;
  logic signed [31:0] load_temp = '0;
  logic [15:0]        load_conc = '0;
  logic               busy, done;
  logic [10:0]        front_position;
  logic signed [31:0] peak_temp, cell_temp;
  logic [1:0]         cell_phase;
  logic               end_check = 1'b0;
  int                 fail_count;

  int issued = 0;
  int dones = 0;
  int burst_left = 1;
  int active_n = 1024;
  bit loaded [1:1024];

  ignition_diffusion_step_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .action(action), .cell_index(cell_index), .load_temp(load_temp),
    .load_conc(load_conc), .front_position(front_position),
    .peak_temp(peak_temp), .cell_temp(cell_temp), .cell_phase(cell_phase)
  );

  ignition_diffusion_step_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .action(action), .cell_index(cell_index), .load_temp(load_temp),
    .load_conc(load_conc), .front_position(front_position),
    .peak_temp(peak_temp), .cell_temp(cell_temp), .cell_phase(cell_phase),
    .end_check(end_check), .fail_count(fail_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (done) dones <= dones + 1;
  end

  // random gaps between bursts of transactions
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic send_item(input logic [1:0] act, input logic [10:0] idx,
                           input logic [31:0] t, input logic [15:0] c);
    start <= 1'b1;
    action <= act;
    cell_index <= idx;
    load_temp <= t;
    load_conc <= c;
    do @(posedge clk); while (busy);
    issued++;
    if (act == ACT_LOAD && idx >= 1 && idx <= 1024) loaded[idx] = 1;
    pace();
  endtask

  // wait for every outstanding result with the unit idle
  task automatic drain();
    start <= 1'b0;
    while (dones != issued || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] dt, input logic [31:0] burn,
                            input logic [31:0] ign, input logic [15:0] diff,
                            input logic [31:0] heat, input logic [10:0] cells);
    drain();
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_BURN_DURATION, burn);
    write_reg(REG_IGNITION_TEMP, ign);
    write_reg(REG_DIFFUSION, {16'h0, diff});
    write_reg(REG_HEAT_GAIN, heat);
    write_reg(REG_CELL_COUNT, {21'h0, cells});
    wr_en <= 1'b0;
    active_n = (cells < 3) ? 3 : ((cells > 1024) ? 1024 : int'(cells));
  endtask

  function automatic logic [31:0] pick_temp();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($urandom_range(0, 16 * 65536)) - 32'd524288;
    endcase
  endfunction

  function automatic logic [15:0] pick_conc();
    return ($urandom_range(0, 7) == 0) ? 16'd32768 : 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [10:0] bad_index();
    return ($urandom_range(0, 2) == 0) ? 11'd0 : 11'($urandom_range(1025, 2047));
  endfunction

  // cell that was loaded already, never an untouched one
  function automatic logic [10:0] known_index();
    int k;
    k = $urandom_range(1, 1024);
    if (!loaded[k]) k = $urandom_range(1, active_n);
    return 11'(k);
  endfunction

  task automatic fill_active();
    for (int i = 1; i <= active_n; i++) send_item(ACT_LOAD, 11'(i), pick_temp(), pick_conc());
  endtask

  task automatic random_mix(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_item(ACT_STEP, 11'($urandom), $urandom, 16'($urandom));
      else if (r < 65)
        send_item(ACT_READ, ($urandom_range(0, 5) == 0) ? bad_index() : known_index(),
                  $urandom, 16'($urandom));
      else if (r < 94) begin
        case ($urandom_range(0, 5))
          0: send_item(ACT_LOAD, bad_index(), pick_temp(), pick_conc());
          1: send_item(ACT_LOAD, 11'($urandom_range(1, 1024)), pick_temp(), pick_conc());
          default: send_item(ACT_LOAD, 11'($urandom_range(1, active_n)), pick_temp(),
                             pick_conc());
        endcase
      end else send_item(2'd3, 11'($urandom), $urandom, 16'($urandom));
    end
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 4))
      0: return 32'd1;
      1: return 32'hffff_ffff;
      default: return 32'($urandom_range(1, 4 * 65536));
    endcase
  endfunction

  initial begin
    logic [31:0] ign, heat;
    logic [15:0] diff;
    logic [10:0] cells;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    drain();

    // directed: invalid reads, unused action, saturation on a three cell grid
    send_item(ACT_READ, 11'd0, 32'h0, 16'h0);
    send_item(ACT_READ, 11'd2047, 32'hffff_ffff, 16'hffff);
    send_item(2'd3, 11'd5, 32'h0, 16'h0);
    set_config(32'd65536, 32'd65536, 32'sd65536, 16'd32768, 32'hffff_ffff, 11'd3);
    send_item(ACT_LOAD, 11'd1, 32'h7fff_ffff, 16'd32768);
    send_item(ACT_LOAD, 11'd2, 32'h8000_0000, 16'd0);
    send_item(ACT_LOAD, 11'd3, 32'h7fff_ffff, 16'd32768);
    send_item(ACT_LOAD, 11'd0, 32'h1234_5678, 16'd100);
    send_item(ACT_LOAD, 11'd1025, 32'h1234_5678, 16'd100);
    send_item(ACT_LOAD, 11'd1024, 32'h8000_0000, 16'd32768);
    send_item(ACT_STEP, 11'd0, 32'h0, 16'h0);
    send_item(ACT_READ, 11'd1, 32'h0, 16'h0);
    send_item(ACT_READ, 11'd2, 32'h0, 16'h0);
    send_item(ACT_READ, 11'd3, 32'h0, 16'h0);
    send_item(ACT_READ, 11'd1024, 32'h0, 16'h0);
    send_item(ACT_STEP, 11'd0, 32'h0, 16'h0);
    send_item(ACT_STEP, 11'd0, 32'h0, 16'h0);
    send_item(ACT_READ, 11'd2, 32'h0, 16'h0);
    send_item(ACT_READ, 11'd1025, 32'h0, 16'h0);
    // count below range clamps to three, ignition at the bottom lights everything
    set_config(32'hffff_ffff, 32'd1, 32'h8000_0000, 16'd0, 32'd0, 11'd0);
    send_item(ACT_STEP, 11'd0, 32'h0, 16'h0);
    send_item(ACT_STEP, 11'd0, 32'h0, 16'h0);
    send_item(ACT_READ, 11'd1, 32'h0, 16'h0);

    // random phases on small grids
    for (int p = 0; p < 9; p++) begin
      case ($urandom_range(0, 4))
        0: ign = 32'h7fff_ffff;
        1: ign = 32'h8000_0000;
        default: ign = 32'($urandom_range(0, 8 * 65536)) - 32'd262144;
      endcase
      case ($urandom_range(0, 3))
        0: diff = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'd32768;
        default: diff = 16'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(0, 3))
        0: heat = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'hffff_ffff;
        1: heat = $urandom;
        default: heat = 32'($urandom_range(0, 4 * 65536));
      endcase
      cells = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 2))
                                          : 11'($urandom_range(3, 12));
      set_config(pick_time(), pick_time(), ign, diff, heat, cells);
      fill_active();
      random_mix(22);
    end

    drain();
    repeat (20) @(posedge clk);
    end_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS ignition_diffusion_step_unit");
    end else begin
      $display("FAIL ignition_diffusion_step_unit");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #8_000_000;
    $display("FAIL ignition_diffusion_step_unit");
    $finish;
  end

endmodule
